@@ hw/rtl/assert_macros.svh @@
// assertion helpers for the rtl, compiled out with ASSERT_OFF
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");
// invariant checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, cond)
`endif
`endif

@@ hw/rtl/pia_pkg.sv @@
package pia_pkg;

  // sizes
  localparam int FREE_DEPTH = 64;
  localparam int ID_WIDTH   = 31;
  localparam int NFP_W      = ID_WIDTH + 1;
  localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
  localparam int ADDR_W     = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;

  // first page number past the id space
  localparam logic [NFP_W-1:0] ID_LIMIT = NFP_W'(1) << ID_WIDTH;

  // request opcodes
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // response status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_ID       = 3'd1,
    ST_ALREADY_FREE = 3'd2,
    ST_FULL         = 3'd3,
    ST_EXHAUSTED    = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_DONE
  } state_t;

  // commands from the sequencer to the free stack
  typedef struct packed {
    logic                scan_start;
    logic                pop;
    logic                push;
    logic [ID_WIDTH-1:0] page;
  } stk_cmd_t;

  // status from the free stack to the sequencer
  typedef struct packed {
    logic                scan_done;
    logic                found;
    logic                pop_done;
    logic [ID_WIDTH-1:0] pop_page;
    logic                empty;
    logic                full;
    logic [CNT_W-1:0]    count;
  } stk_stat_t;

endpackage

@@ hw/rtl/pia_if.sv @@
// request channel
interface pia_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic [pia_pkg::ID_WIDTH-1:0] page_number;

  modport source (output valid, output op, output page_number, input ready);
  modport sink (input valid, input op, input page_number, output ready);
endinterface

// response channel
interface pia_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pia_pkg::ID_WIDTH-1:0] given_page;
  logic                         is_allocated;
  logic [2:0]                   status;

  modport source (output valid, output given_page, output is_allocated, output status,
                  input ready);
  modport sink (input valid, input given_page, input is_allocated, input status,
                output ready);
endinterface

// configuration write channel
interface pia_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pia_pkg::ID_WIDTH-1:0] reserved_page;

  modport source (output valid, output reserved_page, input ready);
  modport sink (input valid, input reserved_page, output ready);
endinterface

@@ hw/rtl/pia_free_stack.sv @@
module pia_free_stack (
  input  logic               clk,
  input  logic               rst,
  input  pia_pkg::stk_cmd_t  cmd,
  output pia_pkg::stk_stat_t stat
);

  logic [pia_pkg::ID_WIDTH-1:0] mem [pia_pkg::FREE_DEPTH];
  logic [pia_pkg::CNT_W-1:0]    count;
  logic [pia_pkg::CNT_W-1:0]    idx;
  logic [pia_pkg::CNT_W-1:0]    top_idx;
  logic                         scanning;
  logic                         rd_pend;
  logic                         pop_pend;
  logic                         found;
  logic [pia_pkg::ID_WIDTH-1:0] key;
  logic [pia_pkg::ID_WIDTH-1:0] rdata;
  logic                         scan_rd;
  logic                         scan_done;
  logic                         rd_en;
  logic [pia_pkg::ADDR_W-1:0]   rd_addr;

  // read port steering: pop reads the top, scan walks from the bottom
  assign top_idx   = count - pia_pkg::CNT_W'(1);
  assign scan_rd   = scanning && (idx != count);
  assign scan_done = scanning && (idx == count) && !rd_pend;
  assign rd_en     = cmd.pop | scan_rd;
  assign rd_addr   = cmd.pop ? top_idx[pia_pkg::ADDR_W-1:0] : idx[pia_pkg::ADDR_W-1:0];

  // stack memory write port
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count[pia_pkg::ADDR_W-1:0]] <= cmd.page;
    end
  end

  // stack memory registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // fill count and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      scanning <= 1'b0;
      rd_pend  <= 1'b0;
      pop_pend <= 1'b0;
    end else begin
      pop_pend <= cmd.pop;
      rd_pend  <= scan_rd;
      if (cmd.pop) begin
        count <= top_idx;
      end else if (cmd.push) begin
        count <= count + pia_pkg::CNT_W'(1);
      end
      if (cmd.scan_start) begin
        scanning <= 1'b1;
      end else if (scan_done) begin
        scanning <= 1'b0;
      end
    end
  end

  // shared compare unit, one entry per cycle
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx   <= '0;
      found <= 1'b0;
      key   <= cmd.page;
    end else begin
      if (scan_rd) begin
        idx <= idx + pia_pkg::CNT_W'(1);
      end
      if (rd_pend && (rdata == key)) begin
        found <= 1'b1;
      end
    end
  end

  // status back to the sequencer
  always_comb begin
    stat.scan_done = scan_done;
    stat.found     = found;
    stat.pop_done  = pop_pend;
    stat.pop_page  = rdata;
    stat.empty     = (count == '0);
    stat.full      = (count == pia_pkg::CNT_W'(pia_pkg::FREE_DEPTH));
    stat.count     = count;
  end

endmodule

@@ hw/rtl/page_id_allocator.sv @@
// page number allocator with a lifo free stack
// req channel: op (allocate, free, query) and page_number; one request at a
// time, req.ready is low from acceptance until the response is staged.
// rsp channel: given_page, is_allocated and status, one response per request.
// cfg channel: reserved_page write, always ready; write only while idle.
// allocate from the stack pops the top entry and stages the page read back;
// allocate from the fresh counter and rejected requests are staged directly.
// free and query of a live page scan the stack through one compare unit,
// one entry per cycle, over up to 64 entries at a full stack.
// the response sits in an output register; a stalled receiver holds it
// there, and a finished request waits until that register is free before
// the next request is taken.
// reset (rst, synchronous) empties the stack, sets the fresh counter to 1
// and the reserved page to 0; stack entries themselves are not cleared.
// once the counter runs past the id space it saturates and allocate from the
// fresh counter returns status ids exhausted.
`include "assert_macros.svh"

module page_id_allocator (
  input  logic           clk,
  input  logic           rst,
  pia_req_if.sink        req,
  pia_rsp_if.source      rsp,
  pia_cfg_if.sink        cfg
);

  pia_pkg::state_t              state;
  pia_pkg::state_t              state_next;
  pia_pkg::stk_cmd_t            cmd;
  pia_pkg::stk_stat_t           stat;

  logic [pia_pkg::ID_WIDTH-1:0] reserved_page;
  logic [pia_pkg::NFP_W-1:0]    next_fresh_page;
  logic [1:0]                   op_q;
  logic [pia_pkg::ID_WIDTH-1:0] page_q;
  logic [pia_pkg::ID_WIDTH-1:0] res_given;
  logic                         res_alloc;
  logic [2:0]                   res_status;
  logic                         rsp_valid;
  logic [pia_pkg::ID_WIDTH-1:0] rsp_given;
  logic                         rsp_alloc;
  logic [2:0]                   rsp_status;

  logic                         accept;
  logic                         load_out;
  logic [pia_pkg::NFP_W-1:0]    page_ext;
  logic                         page_ge;
  logic                         page_res;
  logic                         free_bad;
  logic                         res_hit;
  logic [pia_pkg::NFP_W-1:0]    cand;
  logic [pia_pkg::NFP_W-1:0]    cand_next;
  logic                         exhausted;
  logic [pia_pkg::ID_WIDTH-1:0] acc_given;
  logic                         acc_alloc;
  logic [2:0]                   acc_status;

  pia_free_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  // request checks against the counter and the reserved page
  assign page_ext  = {1'b0, req.page_number};
  assign page_ge   = page_ext >= next_fresh_page;
  assign page_res  = req.page_number == reserved_page;
  assign free_bad  = page_res || page_ge;
  assign res_hit   = next_fresh_page == {1'b0, reserved_page};
  assign cand      = res_hit ? next_fresh_page + pia_pkg::NFP_W'(1) : next_fresh_page;
  assign cand_next = res_hit ? next_fresh_page + pia_pkg::NFP_W'(2)
                             : next_fresh_page + pia_pkg::NFP_W'(1);
  assign exhausted = cand >= pia_pkg::ID_LIMIT;

  // configuration port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved_page <= '0;
    end else if (cfg.valid) begin
      reserved_page <= cfg.reserved_page;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pia_pkg::S_IDLE: begin
        if (req.valid) begin
          case (req.op)
            pia_pkg::OP_ALLOC: state_next = stat.empty ? pia_pkg::S_DONE : pia_pkg::S_POP;
            pia_pkg::OP_FREE:  state_next = free_bad ? pia_pkg::S_DONE : pia_pkg::S_SCAN;
            pia_pkg::OP_QUERY: begin
              state_next = (page_ge || page_res) ? pia_pkg::S_DONE : pia_pkg::S_SCAN;
            end
            default:           state_next = pia_pkg::S_DONE;
          endcase
        end
      end
      pia_pkg::S_POP: begin
        if (stat.pop_done) state_next = pia_pkg::S_DONE;
      end
      pia_pkg::S_SCAN: begin
        if (stat.scan_done) state_next = pia_pkg::S_DONE;
      end
      pia_pkg::S_DONE: begin
        if (!rsp_valid || rsp.ready) state_next = pia_pkg::S_IDLE;
      end
      default: state_next = pia_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pia_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer outputs
  always_comb begin
    req.ready      = (state == pia_pkg::S_IDLE);
    accept         = req.ready && req.valid;
    load_out       = (state == pia_pkg::S_DONE) && (!rsp_valid || rsp.ready);
    cmd.pop        = accept && (req.op == pia_pkg::OP_ALLOC) && !stat.empty;
    cmd.scan_start = accept && (((req.op == pia_pkg::OP_FREE) && !free_bad) ||
                                ((req.op == pia_pkg::OP_QUERY) && !page_ge && !page_res));
    cmd.push       = (state == pia_pkg::S_SCAN) && stat.scan_done &&
                     (op_q == pia_pkg::OP_FREE) && !stat.found && !stat.full;
    cmd.page       = (state == pia_pkg::S_IDLE) ? req.page_number : page_q;
  end

  // fresh page counter, saturating at the end of the id space
  always_ff @(posedge clk) begin
    if (rst) begin
      next_fresh_page <= pia_pkg::NFP_W'(1);
    end else if (accept && (req.op == pia_pkg::OP_ALLOC) && stat.empty) begin
      next_fresh_page <= exhausted ? pia_pkg::ID_LIMIT : cand_next;
    end
  end

  // result known at acceptance
  always_comb begin
    acc_given  = '0;
    acc_alloc  = 1'b0;
    acc_status = pia_pkg::ST_OK;
    case (req.op)
      pia_pkg::OP_ALLOC: begin
        if (stat.empty) begin
          if (exhausted) begin
            acc_status = pia_pkg::ST_EXHAUSTED;
          end else begin
            acc_given = cand[pia_pkg::ID_WIDTH-1:0];
          end
        end
      end
      pia_pkg::OP_FREE: begin
        if (free_bad) acc_status = pia_pkg::ST_BAD_ID;
      end
      pia_pkg::OP_QUERY: begin
        if (!page_ge && page_res) acc_alloc = 1'b1;
      end
      default: ;
    endcase
  end

  // request capture and result assembly
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= req.op;
      page_q     <= req.page_number;
      res_given  <= acc_given;
      res_alloc  <= acc_alloc;
      res_status <= acc_status;
    end else if ((state == pia_pkg::S_POP) && stat.pop_done) begin
      res_given <= stat.pop_page;
    end else if ((state == pia_pkg::S_SCAN) && stat.scan_done) begin
      if (op_q == pia_pkg::OP_FREE) begin
        if (stat.found) begin
          res_status <= pia_pkg::ST_ALREADY_FREE;
        end else if (stat.full) begin
          res_status <= pia_pkg::ST_FULL;
        end
      end else begin
        res_alloc <= !stat.found;
      end
    end
  end

  // response output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp_given  <= res_given;
      rsp_alloc  <= res_alloc;
      rsp_status <= res_status;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.given_page   = rsp_given;
  assign rsp.is_allocated = rsp_alloc;
  assign rsp.status       = rsp_status;

  // checks
  `ASSERT_IMPL(a_exhausted_no_page, clk, rst, rsp.valid && (rsp.status == pia_pkg::ST_EXHAUSTED), rsp.given_page == '0)
  `ASSERT_ALWAYS(a_counter_saturates, clk, rst, next_fresh_page <= pia_pkg::ID_LIMIT)
  `ASSERT_ALWAYS(a_stack_bounded, clk, rst, stat.count <= pia_pkg::CNT_W'(pia_pkg::FREE_DEPTH))
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, req.valid && req.ready, !req.ready)

endmodule
